// ===== sv/rrrs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the rounded-rectangle radii scaler.
// Holds the default widths used by the top level (the coordinate width also by its checker); depends on nothing.
package rrrs_pkg;

    // Width of one signed input coordinate or radius.
    localparam int unsigned DEF_COORD_BITS      = 24;
    // Fraction bits of the scale factor.
    localparam int unsigned DEF_SCALE_FRAC_BITS = 16;

    // Width of tdata for a given number of bits, padded up to whole bytes.
    function automatic int unsigned byte_pad(input int unsigned bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== sv/rounded_rect_radii_scaler.sv =====
`timescale 1ns / 1ps
// Rounded-rectangle corner radii scaler: fits four corner radii into a rectangle.
// Depends on rrrs_pkg for default widths and byte padding.
// Registered stages from input to output: A, B, the divider stages, M and P.
// Throughput: one item per cycle while the output is not held; the four side dividers are pipelined one
// quotient bit per stage, so the divider depth sets the latency.
// Reset: synchronous, active low; clears every stage's valid bit, payload is not reset.
module rounded_rect_radii_scaler #(
    parameter int unsigned COORD_BITS      = rrrs_pkg::DEF_COORD_BITS,
    parameter int unsigned SCALE_FRAC_BITS = rrrs_pkg::DEF_SCALE_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // From bit 0 up: rect_left, rect_top, rect_right, rect_bottom, tl_width, tl_height,
    // tr_width, tr_height, bl_width, bl_height, br_width, br_height; zero padding.
    input  logic [rrrs_pkg::byte_pad(12*COORD_BITS)-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // From bit 0 up: out_tl_width, out_tl_height, out_tr_width, out_tr_height,
    // out_bl_width, out_bl_height, out_br_width, out_br_height; zero padding.
    output logic [rrrs_pkg::byte_pad(8*(COORD_BITS-1))-1:0] o_m_tdata
);
    import rrrs_pkg::*;

    localparam int unsigned C      = COORD_BITS;
    localparam int unsigned S      = SCALE_FRAC_BITS;
    localparam int unsigned OUT_W  = 8 * (C - 1);
    localparam int unsigned OUT_PW = byte_pad(OUT_W);
    localparam logic [S:0]  SCALE_ONE = {1'b1, {S{1'b0}}};

    typedef logic [C-2:0] t_rad;
    typedef struct packed {
        logic           zero;
        t_rad [7:0]     r;
    } t_item;
    typedef struct packed {
        logic           ovf;
        logic [C-1:0]   sum;
        logic [C-1:0]   rem;
        logic [S-1:0]   q;
    } t_div;

    // Whole pipeline advances together unless the output is held.
    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // Stage A: clamp corners and take rectangle spans.
    logic         r_a_v;
    t_item        r_a_item;
    logic [C-1:0] r_a_w, r_a_h;
    t_item        n_a_item;
    logic [C-1:0] n_a_w, n_a_h;

    always_comb begin
        logic signed [C:0]   dw, dh;
        logic signed [C-1:0] rw, rh;
        dw = (C+1)'(signed'(i_s_tdata[2*C +: C])) - (C+1)'(signed'(i_s_tdata[0 +: C]));
        dh = (C+1)'(signed'(i_s_tdata[3*C +: C])) - (C+1)'(signed'(i_s_tdata[C +: C]));
        n_a_w = dw[C] ? C'(-dw) : C'(dw);
        n_a_h = dh[C] ? C'(-dh) : C'(dh);
        n_a_item.zero = 1'b0;
        for (int k = 0; k < 4; k++) begin
            rw = signed'(i_s_tdata[(4+2*k)*C +: C]);
            rh = signed'(i_s_tdata[(5+2*k)*C +: C]);
            // A corner with a non-positive extent collapses to nothing.
            if (rw <= 0 || rh <= 0) begin
                n_a_item.r[2*k]   = '0;
                n_a_item.r[2*k+1] = '0;
            end else begin
                n_a_item.r[2*k]   = rw[C-2:0];
                n_a_item.r[2*k+1] = rh[C-2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_item <= n_a_item;
            r_a_w    <= n_a_w;
            r_a_h    <= n_a_h;
        end
    end

    // Stage B: radius sums per side and overflow test; feeds divider stage 0.
    logic  r_v    [0:S];
    t_item r_item [0:S];
    t_div  r_div  [0:S][0:3];
    t_div  n_b_div [0:3];
    t_item n_b_item;

    always_comb begin
        logic [C-1:0] side;
        n_b_item      = r_a_item;
        n_b_item.zero = (r_a_w == '0) || (r_a_h == '0);
        for (int k = 0; k < 4; k++) begin
            side = (k < 2) ? r_a_w : r_a_h;
            case (k)
                0:       n_b_div[k].sum = C'(r_a_item.r[0]) + C'(r_a_item.r[2]);
                1:       n_b_div[k].sum = C'(r_a_item.r[4]) + C'(r_a_item.r[6]);
                2:       n_b_div[k].sum = C'(r_a_item.r[1]) + C'(r_a_item.r[5]);
                default: n_b_div[k].sum = C'(r_a_item.r[3]) + C'(r_a_item.r[7]);
            endcase
            n_b_div[k].ovf = n_b_div[k].sum > side;
            n_b_div[k].rem = side;
            n_b_div[k].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item[0] <= n_b_item;
            for (int k = 0; k < 4; k++) begin
                r_div[0][k] <= n_b_div[k];
            end
        end
    end

    // One restoring-division step: one quotient bit of side / sum.
    function automatic t_div div_step(input t_div d);
        t_div        o;
        logic [C:0]  rs;
        logic        ge;
        o  = d;
        rs = {d.rem, 1'b0};
        ge = rs >= {1'b0, d.sum};
        o.rem = ge ? C'(rs - {1'b0, d.sum}) : C'(rs);
        o.q   = {d.q[S-2:0], ge};
        return o;
    endfunction

    // Divider pipeline: S stages, one quotient bit each.
    for (genvar g = 0; g < S; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_item[g+1] <= r_item[g];
                for (int k = 0; k < 4; k++) begin
                    r_div[g+1][k] <= div_step(r_div[g][k]);
                end
            end
        end
    end

    // Stage M: smallest scale over the overflowing sides.
    logic       r_m_v;
    t_item      r_m_item;
    logic [S:0] r_m_scale;
    logic [S:0] n_m_scale;

    always_comb begin
        logic [S:0] f;
        n_m_scale = SCALE_ONE;
        for (int k = 0; k < 4; k++) begin
            f = r_div[S][k].ovf ? {1'b0, r_div[S][k].q} : SCALE_ONE;
            if (f < n_m_scale) begin
                n_m_scale = f;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_v[S];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_item  <= r_item[S];
            r_m_scale <= n_m_scale;
        end
    end

    // Stage P: scale all eight radii, or zero them for an empty rectangle; this is the output register.
    logic           r_p_v;
    t_rad [7:0]     r_p_out;
    t_rad [7:0]     n_p_out;

    always_comb begin
        logic [C+S-2:0] prod;
        for (int i = 0; i < 8; i++) begin
            prod = (C+S-1)'(r_m_item.r[i]) * (C+S-1)'(r_m_scale[S-1:0]);
            if (r_m_item.zero) begin
                n_p_out[i] = '0;
            end else if (r_m_scale < SCALE_ONE) begin
                n_p_out[i] = prod[C+S-2:S];
            end else begin
                n_p_out[i] = r_m_item.r[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_out <= n_p_out;
        end
    end

    assign o_m_tvalid = r_p_v;
    assign o_m_tdata  = OUT_PW'(r_p_out);

endmodule

// ===== sv/rrrs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the rounded-rectangle radii scaler, with its bind.
// Depends on rrrs_pkg and on rounded_rect_radii_scaler.
module rrrs_props #(
    parameter int unsigned COORD_BITS = rrrs_pkg::DEF_COORD_BITS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_s_tready,
    input logic o_m_tvalid,
    input logic i_m_tready,
    input logic [rrrs_pkg::byte_pad(8*(COORD_BITS-1))-1:0] o_m_tdata
);
    import rrrs_pkg::*;

    // The input side accepts exactly when the output register can move.
    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output register state");

    // A held result keeps its value until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind rounded_rect_radii_scaler rrrs_props #(.COORD_BITS(COORD_BITS)) u_rrrs_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
